@@ sv/fsvm_pkg.sv @@
`timescale 1ns / 1ps
package fsvm_pkg;

  localparam int STACK_DEPTH_DEF = 1024;
  localparam int CALL_DEPTH_DEF = 64;
  localparam int PC_W = 12;
  localparam int QUEUE_DEPTH = 2;
  localparam int IN_TDATA_W = 120;
  localparam int OUT_TDATA_W = 80;

  typedef enum logic [3:0] {
    FN_MOVE = 4'd0,
    FN_SET  = 4'd1,
    FN_ADD  = 4'd2,
    FN_MUL  = 4'd3,
    FN_NEG  = 4'd4,
    FN_NOT  = 4'd5,
    FN_JUMP = 4'd6,
    FN_JZ   = 4'd7,
    FN_CALL = 4'd8,
    FN_RET  = 4'd9,
    FN_LT   = 4'd10,
    FN_EQ   = 4'd11,
    FN_PUSH = 4'd12
  } func_e;

  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_HALT  = 3'd1;
  localparam logic [2:0] ST_SLOT  = 3'd2;
  localparam logic [2:0] ST_OVF   = 3'd3;
  localparam logic [2:0] ST_BADOP = 3'd4;

  typedef struct packed {
    func_e              op;
    logic               bad;
    logic signed [15:0] d_rel;
    logic signed [15:0] s1_rel;
    logic signed [15:0] s2_rel;
    logic [PC_W-1:0]    tgt;
    logic [63:0]        imm;
  } instr_t;

  typedef struct packed {
    logic clearing;
    logic halted;
  } bk_stat_t;

endpackage

@@ sv/fsvm_front.sv @@
`timescale 1ns / 1ps
module fsvm_front import fsvm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  hold_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  input  logic                  q_full_i,
  output logic                  push_o,
  output instr_t                instr_o
);

  logic [3:0] func;
  logic [15:0] a1, a2, a3;

  assign func = s_axis_tdata[3:0];
  assign a1 = s_axis_tdata[19:4];
  assign a2 = s_axis_tdata[35:20];
  assign a3 = s_axis_tdata[51:36];

  assign s_axis_tready = !q_full_i && !hold_i;
  assign push_o = s_axis_tvalid && s_axis_tready;

  always_comb begin
    instr_o.op = FN_MOVE;
    instr_o.bad = 1'b0;
    instr_o.d_rel = a1;
    instr_o.s1_rel = a2;
    instr_o.s2_rel = a3;
    instr_o.tgt = a1[PC_W-1:0];
    instr_o.imm = s_axis_tdata[115:52];
    unique case (func)
      FN_MOVE: instr_o.op = FN_MOVE;
      FN_SET: instr_o.op = FN_SET;
      FN_ADD: instr_o.op = FN_ADD;
      FN_MUL: instr_o.op = FN_MUL;
      FN_NEG: instr_o.op = FN_NEG;
      FN_NOT: instr_o.op = FN_NOT;
      FN_JUMP: instr_o.op = FN_JUMP;
      FN_JZ: begin
        instr_o.op = FN_JZ;
        instr_o.s1_rel = a1;
        instr_o.tgt = a2[PC_W-1:0];
      end
      FN_CALL: instr_o.op = FN_CALL;
      FN_RET: begin
        instr_o.op = FN_RET;
        instr_o.s1_rel = a1;
      end
      FN_LT: instr_o.op = FN_LT;
      FN_EQ: instr_o.op = FN_EQ;
      FN_PUSH: begin
        instr_o.op = FN_PUSH;
        instr_o.d_rel = '0;
      end
      default: instr_o.bad = 1'b1;
    endcase
  end

endmodule

@@ sv/fsvm_queue.sv @@
`timescale 1ns / 1ps
module fsvm_queue import fsvm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  instr_t data_i,
  output logic   full_o,
  output logic   valid_o,
  input  logic   pop_i,
  output instr_t data_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  instr_t slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o = cnt_q == CW'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o = slot_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && valid_o;

  always_comb begin
    wp_d = wp_q;
    rp_d = rp_q;
    if (do_push) wp_d = (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
    if (do_pop) rp_d = (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
    cnt_d = cnt_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wp_q] <= data_i;
  end

endmodule

@@ sv/fsvm_back.sv @@
`timescale 1ns / 1ps
module fsvm_back import fsvm_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int CALL_DEPTH = CALL_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  instr_t                 q_data_i,
  output logic                   q_pop_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output bk_stat_t               stat_o
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int FPW = $clog2(STACK_DEPTH + 1);
  localparam int SW = ((FPW > 16) ? FPW : 16) + 2;
  localparam int CIW = $clog2(CALL_DEPTH);
  localparam int DW = $clog2(CALL_DEPTH + 1);
  localparam int CSW = PC_W + 32;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_MUL   = 2'd3;

  logic [63:0] vmem [STACK_DEPTH];
  logic [CSW-1:0] cmem [CALL_DEPTH];

  logic [1:0] st_q, st_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [FPW-1:0] fp_q, fp_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic [DW-1:0] dep_q, dep_d;
  logic halt_q, halt_d;
  instr_t in_q;
  logic [AW-1:0] da_q;
  logic dok_q, s1ok_q, s2ok_q;
  logic [63:0] x_q, y_q;
  logic [CSW-1:0] cs_q;
  logic [63:0] ll_q, ll_d;
  logic [31:0] lh_q, lh_d, hl_q, hl_d;
  logic ov_q, ov_d;
  logic [OUT_TDATA_W-1:0] od_q, od_d;

  logic signed [SW-1:0] fps, da_s, s1a_s, s2a_s, cfp, rfp, rd_s;
  logic dok, s1ok, s2ok, cok, rok;
  logic re, we, cwe, out_free;
  logic [AW-1:0] wa;
  logic [63:0] wd, v;
  logic [2:0] sts;
  logic [63:0] rv;
  logic [PC_W-1:0] npc;
  logic signed [15:0] cs_fsz, cs_rslot;
  logic [PC_W-1:0] cs_pc;

  assign fps = $signed(SW'({1'b0, fp_q}));
  assign da_s = fps + SW'(q_data_i.d_rel);
  assign s1a_s = fps + SW'(q_data_i.s1_rel);
  assign s2a_s = fps + SW'(q_data_i.s2_rel);
  assign dok = !da_s[SW-1] && (da_s[SW-2:0] < (SW-1)'(STACK_DEPTH));
  assign s1ok = !s1a_s[SW-1] && (s1a_s[SW-2:0] < (SW-1)'(STACK_DEPTH));
  assign s2ok = !s2a_s[SW-1] && (s2a_s[SW-2:0] < (SW-1)'(STACK_DEPTH));

  assign cs_pc = cs_q[CSW-1:32];
  assign cs_fsz = cs_q[31:16];
  assign cs_rslot = cs_q[15:0];
  assign cfp = fps + SW'(in_q.s1_rel);
  assign cok = !cfp[SW-1] && (cfp[SW-2:0] <= (SW-1)'(STACK_DEPTH));
  assign rfp = fps - SW'(cs_fsz);
  assign rd_s = rfp + SW'(cs_rslot);
  assign rok = !rfp[SW-1] && (rfp[SW-2:0] <= (SW-1)'(STACK_DEPTH))
               && !rd_s[SW-1] && (rd_s[SW-2:0] < (SW-1)'(STACK_DEPTH));

  assign out_free = !ov_q || m_axis_tready;
  assign q_pop_o = (st_q == S_ISSUE) && q_valid_i;
  assign re = q_pop_o;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = od_q;
  assign stat_o.clearing = st_q == S_CLEAR;
  assign stat_o.halted = halt_q;

  always_comb begin
    st_d = st_q;
    clr_d = clr_q;
    fp_d = fp_q;
    pc_d = pc_q;
    dep_d = dep_q;
    halt_d = halt_q;
    ll_d = x_q[31:0] * y_q[31:0];
    lh_d = x_q[31:0] * y_q[63:32];
    hl_d = x_q[63:32] * y_q[31:0];
    ov_d = ov_q && !m_axis_tready;
    od_d = od_q;
    we = 1'b0;
    cwe = 1'b0;
    wa = da_q;
    wd = '0;
    v = '0;
    sts = ST_RUN;
    rv = '0;
    npc = pc_q + 1'b1;
    unique case (st_q)
      S_CLEAR: begin
        we = 1'b1;
        wa = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(STACK_DEPTH - 1)) st_d = S_ISSUE;
      end
      S_ISSUE: begin
        if (q_valid_i) st_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          if (halt_q) begin
            sts = ST_HALT;
            npc = pc_q;
          end else if (in_q.bad) begin
            sts = ST_BADOP;
          end else begin
            unique case (in_q.op)
              FN_MOVE, FN_NEG, FN_NOT: begin
                if (dok_q && s1ok_q) begin
                  unique case (in_q.op)
                    FN_NEG: v = 64'd0 - x_q;
                    FN_NOT: v = {63'd0, x_q == 64'd0};
                    default: v = x_q;
                  endcase
                  we = 1'b1;
                  wd = v;
                end else sts = ST_SLOT;
              end
              FN_SET: begin
                if (dok_q) begin
                  we = 1'b1;
                  wd = in_q.imm;
                end else sts = ST_SLOT;
              end
              FN_ADD, FN_LT, FN_EQ: begin
                if (dok_q && s1ok_q && s2ok_q) begin
                  unique case (in_q.op)
                    FN_LT: v = {63'd0, $signed(x_q) < $signed(y_q)};
                    FN_EQ: v = {63'd0, x_q == y_q};
                    default: v = x_q + y_q;
                  endcase
                  we = 1'b1;
                  wd = v;
                end else sts = ST_SLOT;
              end
              FN_MUL: begin
                if (!(dok_q && s1ok_q && s2ok_q)) sts = ST_SLOT;
              end
              FN_JUMP: npc = in_q.tgt;
              FN_JZ: begin
                if (!s1ok_q) sts = ST_SLOT;
                else if (x_q == 64'd0) npc = in_q.tgt;
              end
              FN_CALL: begin
                if (dep_q >= DW'(CALL_DEPTH)) sts = ST_OVF;
                else if (!cok) sts = ST_SLOT;
                else begin
                  cwe = 1'b1;
                  dep_d = dep_q + 1'b1;
                  fp_d = cfp[FPW-1:0];
                  npc = in_q.tgt;
                end
              end
              FN_RET: begin
                if (!s1ok_q) sts = ST_SLOT;
                else if (dep_q == '0) begin
                  sts = ST_HALT;
                  rv = x_q;
                  npc = pc_q;
                  halt_d = 1'b1;
                end else if (!rok) sts = ST_SLOT;
                else begin
                  fp_d = rfp[FPW-1:0];
                  we = 1'b1;
                  wa = rd_s[AW-1:0];
                  wd = x_q;
                  npc = cs_pc;
                  dep_d = dep_q - 1'b1;
                end
              end
              FN_PUSH: begin
                npc = pc_q;
                if (dok_q) begin
                  we = 1'b1;
                  wd = in_q.imm;
                  fp_d = fp_q + 1'b1;
                end else sts = ST_SLOT;
              end
              default: sts = ST_BADOP;
            endcase
          end
          if (sts == ST_SLOT || sts == ST_OVF || sts == ST_BADOP) npc = pc_q;
          if (!halt_q && !in_q.bad && in_q.op == FN_MUL && sts == ST_RUN) begin
            st_d = S_MUL;
          end else begin
            if (!halt_q) pc_d = npc;
            ov_d = 1'b1;
            od_d = {1'b0, rv, sts, npc};
            st_d = S_ISSUE;
          end
        end
      end
      S_MUL: begin
        if (out_free) begin
          we = 1'b1;
          wd = ll_q + {lh_q + hl_q, 32'd0};
          pc_d = npc;
          ov_d = 1'b1;
          od_d = {1'b0, 64'd0, ST_RUN, npc};
          st_d = S_ISSUE;
        end
      end
      default: st_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLEAR;
      clr_q <= '0;
      fp_q <= '0;
      pc_q <= '0;
      dep_q <= '0;
      halt_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      clr_q <= clr_d;
      fp_q <= fp_d;
      pc_q <= pc_d;
      dep_q <= dep_d;
      halt_q <= halt_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
    ll_q <= ll_d;
    lh_q <= lh_d;
    hl_q <= hl_d;
    if (re) begin
      in_q <= q_data_i;
      da_q <= da_s[AW-1:0];
      dok_q <= dok;
      s1ok_q <= s1ok;
      s2ok_q <= s2ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) vmem[wa] <= wd;
    if (re) begin
      x_q <= vmem[s1a_s[AW-1:0]];
      y_q <= vmem[s2a_s[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cwe) cmem[dep_q[CIW-1:0]] <= {pc_q + 1'b1, in_q.s1_rel, in_q.s2_rel};
    if (re) cs_q <= cmem[CIW'(dep_q - 1'b1)];
  end

endmodule

@@ sv/frame_stack_vm_execute.sv @@
`timescale 1ns / 1ps
// Frame-stack VM execute unit. Each input request is one instruction (or an
// argument push) and yields exactly one result: next pc, status, return value.
// A decoder stage feeds a two-entry queue; the execute engine reads both
// operands from a dual-read value memory as it pops an instruction and writes
// back in its execute state, which waits while the output is held; a multiply
// adds a further state (three 32x32 partial products, then a sum). After reset
// the engine clears the value memory, one word per cycle; s_axis_tready stays
// low during that pass.
module frame_stack_vm_execute import fsvm_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int CALL_DEPTH = CALL_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // func[3:0], arg1[19:4], arg2[35:20], arg3[51:36], imm[115:52], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // next_pc[11:0], status[14:12], ret_value[78:15], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic q_full, q_push, q_valid, q_pop;
  instr_t fr_instr, q_instr;
  bk_stat_t bk_stat;

  fsvm_front u_front (
    .clk_i,
    .rst_ni,
    .hold_i        (bk_stat.clearing),
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .q_full_i      (q_full),
    .push_o        (q_push),
    .instr_o       (fr_instr)
  );

  fsvm_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .data_i  (fr_instr),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_instr)
  );

  fsvm_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .CALL_DEPTH  (CALL_DEPTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i     (q_valid),
    .q_data_i      (q_instr),
    .q_pop_o       (q_pop),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .stat_o        (bk_stat)
  );

`ifndef SYNTH
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.halted |=> bk_stat.halted) else $error("halt flag dropped");
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.clearing |-> !(s_axis_tvalid && s_axis_tready))
    else $error("request taken during memory clear");
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.clearing |-> !q_pop) else $error("queue popped during memory clear");
`endif

endmodule

@@ tb/frame_stack_vm_execute_tb.sv @@
`timescale 1ns / 1ps
module frame_stack_vm_execute_tb;
  import fsvm_pkg::*;

  localparam int STORE_WORDS = 1024;
  localparam int CALL_LEVELS = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1150;
  localparam logic [3:0] FN_RSVD_A = 4'd13;
  localparam logic [3:0] FN_RSVD_B = 4'd14;
  localparam logic [3:0] FN_RSVD_C = 4'd15;

  typedef struct packed {
    logic [11:0] next_pc;
    logic [2:0]  status;
    logic [63:0] ret_value;
  } vm_result_t;

  class exec_tracker;
    logic [63:0] value_mem [STORE_WORDS];
    int          fp;
    int          pc;
    int          ret_pc [CALL_LEVELS];
    int          fsize [CALL_LEVELS];
    int          rslot [CALL_LEVELS];
    int          depth;
    bit          halted;
    vm_result_t  expected_results [$];
    int          mismatches;
    int          checked;
    int          max_depth;
    int          status_seen [8];

    function new();
      foreach (value_mem[i]) value_mem[i] = '0;
      fp = 0; pc = 0; depth = 0; halted = 0;
      mismatches = 0; checked = 0; max_depth = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function bit slot_at(int base, int rel, output int slot_idx);
      slot_idx = base + rel;
      return slot_idx >= 0 && slot_idx < STORE_WORDS;
    endfunction

    function void retire_instr(logic [3:0] fn, logic [15:0] a1, logic [15:0] a2,
                               logic [15:0] a3, logic [63:0] imm);
      int r1, r2, r3, d, s1, s2, nfp, t, npc;
      bit ok;
      logic [2:0] st;
      logic [63:0] rv, x, y, v;
      r1 = $signed(a1); r2 = $signed(a2); r3 = $signed(a3);
      ok = 1; st = ST_RUN; rv = '0;
      npc = (pc + 1) % 4096;
      if (halted) begin
        st = ST_HALT;
        npc = pc;
      end else begin
        case (fn)
          FN_MOVE, FN_NEG, FN_NOT: begin
            ok = slot_at(fp, r1, d) && slot_at(fp, r2, s1);
            if (ok) begin
              v = value_mem[s1];
              if (fn == FN_NEG) v = -v;
              else if (fn == FN_NOT) v = (v == 0) ? 64'd1 : 64'd0;
              value_mem[d] = v;
            end
          end
          FN_SET: begin
            ok = slot_at(fp, r1, d);
            if (ok) value_mem[d] = imm;
          end
          FN_ADD, FN_MUL, FN_LT, FN_EQ: begin
            ok = slot_at(fp, r1, d) && slot_at(fp, r2, s1) && slot_at(fp, r3, s2);
            if (ok) begin
              x = value_mem[s1];
              y = value_mem[s2];
              if (fn == FN_ADD) v = x + y;
              else if (fn == FN_MUL) v = x * y;
              else if (fn == FN_LT) v = ($signed(x) < $signed(y)) ? 64'd1 : 64'd0;
              else v = (x == y) ? 64'd1 : 64'd0;
              value_mem[d] = v;
            end
          end
          FN_JUMP: npc = a1[11:0];
          FN_JZ: begin
            ok = slot_at(fp, r1, s1);
            if (ok && value_mem[s1] == 0) npc = a2[11:0];
          end
          FN_CALL: begin
            nfp = fp + r2;
            if (depth >= CALL_LEVELS) st = ST_OVF;
            else if (nfp < 0 || nfp > STORE_WORDS) ok = 0;
            else begin
              ret_pc[depth] = (pc + 1) % 4096;
              fsize[depth] = r2;
              rslot[depth] = r3;
              depth++;
              if (depth > max_depth) max_depth = depth;
              fp = nfp;
              npc = a1[11:0];
            end
          end
          FN_RET: begin
            ok = slot_at(fp, r1, s1);
            if (ok) begin
              v = value_mem[s1];
              if (depth == 0) begin
                halted = 1;
                st = ST_HALT;
                rv = v;
                npc = pc;
              end else begin
                t = depth - 1;
                nfp = fp - fsize[t];
                if (nfp < 0 || nfp > STORE_WORDS || !slot_at(nfp, rslot[t], d)) ok = 0;
                else begin
                  fp = nfp;
                  value_mem[d] = v;
                  npc = ret_pc[t];
                  depth = t;
                end
              end
            end
          end
          FN_PUSH: begin
            ok = slot_at(fp, 0, d);
            if (ok) begin
              value_mem[d] = imm;
              fp++;
            end
            npc = pc;
          end
          default: st = ST_BADOP;
        endcase
        if (!ok) st = ST_SLOT;
        if (st == ST_SLOT || st == ST_OVF || st == ST_BADOP) npc = pc;
        pc = npc;
      end
      status_seen[st]++;
      expected_results.push_back('{next_pc: npc[11:0], status: st, ret_value: rv});
    endfunction

    function void match_result(logic [OUT_TDATA_W-1:0] tdata);
      vm_result_t got, exp_r;
      got.next_pc = tdata[11:0];
      got.status = tdata[14:12];
      got.ret_value = tdata[78:15];
      checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: pc=%0d status=%0d ret=%h",
                   got.next_pc, got.status, got.ret_value);
        return;
      end
      exp_r = expected_results.pop_front();
      if (got != exp_r || tdata[OUT_TDATA_W-1:79] != '0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected pc=%0d status=%0d ret=%h, got pc=%0d status=%0d ret=%h",
                   checked, exp_r.next_pc, exp_r.status, exp_r.ret_value,
                   got.next_pc, got.status, got.ret_value);
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  exec_tracker tracker;
  int          cycles;
  bit          quiet;
  int          sent;

  frame_stack_vm_execute u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("frame_stack_vm_execute: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.match_result(m_axis_tdata);
    m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 7);
  end

  task automatic issue(logic [3:0] fn, logic [15:0] a1, logic [15:0] a2,
                       logic [15:0] a3, logic [63:0] imm);
    while (!quiet && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, imm, a3, a2, a1, fn};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.retire_instr(fn, a1, a2, a3, imm);
    sent++;
  endtask

  function automatic logic [15:0] near_slot();
    return 16'($signed($urandom_range(20)) - 4);
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v = '0;
      1: v = 64'($urandom_range(3));
      2: v = {1'b0, {63{1'b1}}};
      3: v = {1'b1, 63'b0};
      default: ;
    endcase
    return v;
  endfunction

  task automatic random_instr();
    logic [3:0] fn;
    logic [15:0] a1, a2, a3;
    int pick;
    pick = $urandom_range(99);
    a1 = near_slot(); a2 = near_slot(); a3 = near_slot();
    if (pick < 12) begin
      fn = 4'($urandom);
      a1 = 16'($urandom); a2 = 16'($urandom); a3 = 16'($urandom);
    end else if (pick < 22) fn = FN_SET;
    else if (pick < 30) fn = FN_PUSH;
    else if (pick < 40) fn = FN_CALL;
    else if (pick < 50) fn = FN_RET;
    else if (pick < 56) begin
      fn = ($urandom_range(1)) ? FN_JUMP : FN_JZ;
      if (fn == FN_JUMP) a1 = 16'($urandom);
      else a2 = 16'($urandom);
    end else fn = 4'($urandom_range(FN_EQ));
    if (fn == FN_RET && tracker.depth == 0) fn = FN_ADD;
    if (fn == FN_CALL) begin
      if ($urandom_range(9) == 0) a2 = 16'($urandom);
      else a2 = 16'($urandom_range(16));
      a3 = 16'($urandom_range(7));
      if (tracker.fp >= 4 && $urandom_range(3) == 0) a2 = 16'(-$signed($urandom_range(4)));
    end
    if (fn == FN_PUSH && tracker.fp > 900) fn = FN_SET;
    issue(fn, a1, a2, a3, rand64());
  endtask

  initial begin
    tracker = new();
    cycles = 0;
    sent = 0;
    quiet = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    issue(FN_SET, 16'd0, 16'd0, 16'd0, {1'b0, {63{1'b1}}});
    issue(FN_SET, 16'd1, 16'd0, 16'd0, {1'b1, 63'b0});
    issue(FN_ADD, 16'd2, 16'd0, 16'd1, '0);
    issue(FN_MUL, 16'd3, 16'd0, 16'd0, '0);
    issue(FN_NEG, 16'd4, 16'd1, 16'd0, '0);
    issue(FN_NOT, 16'd5, 16'd9, 16'd0, '0);
    issue(FN_NOT, 16'd6, 16'd0, 16'd0, '0);
    issue(FN_LT, 16'd7, 16'd1, 16'd0, '0);
    issue(FN_EQ, 16'd8, 16'd0, 16'd0, '0);
    issue(FN_MOVE, 16'd1023, 16'd0, 16'd0, '0);
    issue(FN_JUMP, 16'hFFFF, 16'd0, 16'd0, '0);
    issue(FN_JZ, 16'd9, 16'h8000, 16'd0, '0);
    issue(FN_JZ, 16'd0, 16'h7FFF, 16'd0, '0);
    issue(FN_SET, 16'hFFFF, 16'd0, 16'd0, '1);
    issue(FN_ADD, 16'd0, 16'h7FFF, 16'h8000, '0);
    issue(FN_RSVD_A, 16'd0, 16'd0, 16'd0, '0);
    issue(FN_RSVD_B, 16'd0, 16'd0, 16'd0, '0);
    issue(FN_RSVD_C, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1);
    issue(FN_PUSH, 16'd0, 16'd0, 16'd0, 64'h1234_5678_9ABC_DEF0);
    issue(FN_CALL, 16'd100, 16'h7FFF, 16'd0, '0);
    issue(FN_CALL, 16'd100, 16'h8000, 16'd0, '0);
    issue(FN_CALL, 16'd200, 16'd4, 16'd2, '0);
    issue(FN_RET, 16'hFFFF, 16'd0, 16'd0, '0);

    for (int i = 0; i < CALL_LEVELS + 1; i++) issue(FN_CALL, 16'($urandom), 16'd1, 16'd0, '0);
    while (tracker.depth > 0) issue(FN_RET, 16'd0, 16'd0, 16'd0, '0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= 400 && i < 650);
      random_instr();
    end
    quiet = 0;

    while (tracker.depth > 0) issue(FN_RET, 16'd0, 16'd0, 16'd0, '0);
    issue(FN_RET, 16'd0, 16'd0, 16'd0, '0);
    for (int i = 0; i < 4; i++) random_instr();
    s_axis_tvalid <= 1'b0;

    while (tracker.expected_results.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d instructions sent, %0d results checked, deepest call nesting %0d",
             sent, tracker.checked, tracker.max_depth);
    $display("status counts: run %0d halt %0d slot %0d overflow %0d badop %0d",
             tracker.status_seen[ST_RUN], tracker.status_seen[ST_HALT],
             tracker.status_seen[ST_SLOT], tracker.status_seen[ST_OVF],
             tracker.status_seen[ST_BADOP]);
    if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
      $display("frame_stack_vm_execute: match");
    end else begin
      $display("%0d mismatches", tracker.mismatches);
      $display("frame_stack_vm_execute: mismatch");
    end
    $finish;
  end

endmodule

@@ frame_stack_vm_execute.f @@
sv/fsvm_pkg.sv
sv/fsvm_front.sv
sv/fsvm_queue.sv
sv/fsvm_back.sv
sv/frame_stack_vm_execute.sv
tb/frame_stack_vm_execute_tb.sv
